// ----- hw/rtl/bsmgar_pkg.sv -----
`timescale 1ns / 1ps
// Package for the bounded set minimum gap and range block.
// Holds the sizes, command codes, scan handshake types and the gap function.
// No dependencies.
package bsmgar_pkg;

    // Store geometry.
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

    // Field widths.
    localparam int DATA_W = 32;
    localparam int CAP_W  = 11;
    localparam int CMP_W  = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

    // Reset value of the capacity register and span threshold.
    localparam logic [CAP_W-1:0]   CAP_RESET    = CAP_W'(1024);
    localparam logic [COUNT_W-1:0] MIN_FOR_SPAN = COUNT_W'(2);

    // Command codes.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Request to the scan engine.
    typedef struct packed {
        logic                     start;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] value;
    } scan_req_t;

    // Response from the scan engine.
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] min_gap;
    } scan_rsp_t;

    // Exact absolute difference of two signed numbers as an unsigned quantity.
    function automatic logic [DATA_W-1:0] gap_of(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic [DATA_W-1:0] ua;
        logic [DATA_W-1:0] ub;
        ua = a ^ {1'b1, {(DATA_W-1){1'b0}}};
        ub = b ^ {1'b1, {(DATA_W-1){1'b0}}};
        return (ua >= ub) ? (ua - ub) : (ub - ua);
    endfunction

endpackage

// ----- hw/rtl/bsmgar_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module bsmgar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/bsmgar_scan.sv -----
`timescale 1ns / 1ps
// Scan engine: walks the filled part of the store and finds the smallest gap
// to a new value. Depends on bsmgar_pkg; drives the read port of the store RAM.
module bsmgar_scan
    import bsmgar_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  scan_req_t                req,
    output logic [ADDR_W-1:0]        rd_addr,
    input  logic signed [DATA_W-1:0] rd_data,
    output scan_rsp_t                rsp
);

    logic [COUNT_W-1:0]       addr_reg, addr_next;
    logic [COUNT_W-1:0]       count_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     busy_reg, busy_next;
    logic                     issue_reg, issue_next;
    logic                     pend_reg;
    logic                     gap_vld_reg;
    logic [DATA_W-1:0]        gap_reg;
    logic [DATA_W-1:0]        min_reg, min_next;
    logic                     done;

    // The scan is finished once every read has left the pipeline.
    assign done = busy_reg && !issue_reg && !pend_reg && !gap_vld_reg;

    // Address sequencing and running minimum.
    always_comb
    begin
        addr_next  = addr_reg;
        issue_next = issue_reg;
        busy_next  = busy_reg;
        min_next   = min_reg;
        if (req.start)
        begin
            addr_next  = '0;
            issue_next = (req.count != '0);
            busy_next  = 1'b1;
            min_next   = '1;
        end
        else
        begin
            if (issue_reg)
            begin
                addr_next = addr_reg + COUNT_W'(1);
                if (addr_next == count_reg)
                begin
                    issue_next = 1'b0;
                end
            end
            if (gap_vld_reg && (gap_reg < min_reg))
            begin
                min_next = gap_reg;
            end
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            issue_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            gap_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            issue_reg   <= issue_next;
            pend_reg    <= issue_reg && !req.start;
            gap_vld_reg <= pend_reg && !req.start;
        end
    end

    // Datapath registers: address, operands, gap stage and minimum.
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        min_reg  <= min_next;
        gap_reg  <= gap_of(value_reg, rd_data);
        if (req.start)
        begin
            count_reg <= req.count;
            value_reg <= req.value;
        end
    end

    assign rd_addr     = addr_reg[ADDR_W-1:0];
    assign rsp.done    = done;
    assign rsp.min_gap = min_reg;

endmodule

// ----- hw/rtl/bounded_set_min_gap_and_range.sv -----
`timescale 1ns / 1ps
// Top level of the bounded set minimum gap and range block.
// Depends on bsmgar_pkg, bsmgar_ram and bsmgar_scan.
//
//  Channel   Handshake                 Payload
//  input     in_valid / in_stall       command, value
//  output    out_valid / out_stall     rejected, span_valid, shortest_span,
//                                      longest_span, stored_count
//  config    cfg_write (no wait)       cfg_data -> capacity
//
// An accepted add into a store of n entries scans them through the store RAM's
// read port, one entry a cycle; when the scan is done the value is written to
// the store and the item moves to ST_DONE. A query or a rejected add goes from
// ST_IDLE straight to ST_DONE. From ST_DONE the result enters the output
// register once it is empty or being read. One item is in progress at a time;
// the next is taken once its result sits in the output register, even if stalled.
// Reset clears the count, the extremes and the best gap; the store contents
// are never cleared, since only filled entries are read.
module bounded_set_min_gap_and_range
    import bsmgar_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CAP_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     rejected,
    output logic                     span_valid,
    output logic [DATA_W-1:0]        shortest_span,
    output logic [DATA_W-1:0]        longest_span,
    output logic [CAP_W-1:0]         stored_count
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CAP_W-1:0]         capacity_reg;
    logic [COUNT_W-1:0]       fill_reg, fill_next;
    logic signed [DATA_W-1:0] small_reg, small_next;
    logic signed [DATA_W-1:0] large_reg, large_next;
    logic [DATA_W-1:0]        best_reg, best_next;
    logic signed [DATA_W-1:0] pend_value_reg;
    logic                     rej_reg, rej_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     o_rej_reg;
    logic                     o_span_valid_reg;
    logic [DATA_W-1:0]        o_short_reg;
    logic [DATA_W-1:0]        o_long_reg;
    logic [CAP_W-1:0]         o_count_reg;

    logic                     accept;
    logic                     full;
    logic [CMP_W-1:0]         cap_ext, depth_ext, limit;
    logic                     load_out;
    logic                     have_span;
    scan_req_t                scan_req;
    scan_rsp_t                scan_rsp;
    logic [ADDR_W-1:0]        rd_addr;
    logic [DATA_W-1:0]        rd_data;
    logic                     wr_en;

    // Effective capacity saturates at the store depth.
    assign cap_ext   = CMP_W'(capacity_reg);
    assign depth_ext = CMP_W'(STORE_DEPTH);
    assign limit     = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign full      = CMP_W'(fill_reg) >= limit;

    // Input transactions are taken only between items.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // Start a scan for every add that fits.
    assign scan_req.start = accept && (command == CMD_ADD) && !full;
    assign scan_req.count = fill_reg;
    assign scan_req.value = value;

    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign wr_en     = (state_reg == ST_SCAN) && scan_rsp.done;
    assign have_span = (fill_reg >= MIN_FOR_SPAN);

    // Item sequencing and state update at the end of a scan.
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        small_next = small_reg;
        large_next = large_reg;
        best_next  = best_reg;
        rej_next   = rej_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rej_next = (command == CMD_ADD) && full;
                    state_next = scan_req.start ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    if (scan_rsp.min_gap < best_reg)
                    begin
                        best_next = scan_rsp.min_gap;
                    end
                    if (fill_reg == '0)
                    begin
                        small_next = pend_value_reg;
                        large_next = pend_value_reg;
                    end
                    else
                    begin
                        if (pend_value_reg < small_reg)
                        begin
                            small_next = pend_value_reg;
                        end
                        if (pend_value_reg > large_reg)
                        begin
                            large_next = pend_value_reg;
                        end
                    end
                    fill_next  = fill_reg + COUNT_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and set state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_RESET;
            fill_reg      <= '0;
            small_reg     <= '0;
            large_reg     <= '0;
            best_reg      <= '1;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            small_reg     <= small_next;
            large_reg     <= large_next;
            best_reg      <= best_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // Payload registers: pending value and the result transaction.
    always_ff @(posedge clk)
    begin
        if (scan_req.start)
        begin
            pend_value_reg <= value;
        end
        if (load_out)
        begin
            o_rej_reg        <= rej_reg;
            o_span_valid_reg <= have_span;
            o_short_reg      <= have_span ? best_reg : '0;
            o_long_reg       <= have_span ? DATA_W'(large_reg - small_reg) : '0;
            o_count_reg      <= CAP_W'(fill_reg);
        end
    end

    // Value store.
    bsmgar_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (pend_value_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Nearest-neighbour scan over the filled entries.
    bsmgar_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scan_req),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rsp     (scan_rsp)
    );

    assign out_valid     = out_valid_reg;
    assign rejected      = o_rej_reg;
    assign span_valid    = o_span_valid_reg;
    assign shortest_span = o_short_reg;
    assign longest_span  = o_long_reg;
    assign stored_count  = o_count_reg;

endmodule

// ----- test/bounded_set_min_gap_and_range_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bounded_set_min_gap_and_range.
// Depends on bsmgar_pkg and the block itself; it predicts results from its own set model or takes them from the table.
module bounded_set_min_gap_and_range_tb;
    import bsmgar_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 500;
    localparam int REFILL_ITEMS   = 60;
    localparam int MAX_REPORTS    = 10;
    localparam int LONG_HOLD      = 1200;
    localparam int FIRST_HOLD_AT  = 60;
    localparam int SECOND_HOLD_AT = 320;
    localparam int TAIL_CYCLES    = 16;
    localparam int CYCLE_LIMIT    = 6000000;
    localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

    // One result as the block reports it.
    typedef struct packed {
        logic              rejected;
        logic              span_valid;
        logic [DATA_W-1:0] shortest;
        logic [DATA_W-1:0] longest;
        logic [CAP_W-1:0]  count;
    } span_result_t;

    // One line of the directed stimulus table.
    typedef struct packed {
        logic              write_cap;
        logic [CAP_W-1:0]  cap;
        logic              cmd;
        logic [DATA_W-1:0] val;
        logic              known;
        span_result_t      want;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CAP_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     command;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic                     rejected;
    logic                     span_valid;
    logic [DATA_W-1:0]        shortest_span;
    logic [DATA_W-1:0]        longest_span;
    logic [CAP_W-1:0]         stored_count;

    // Own model of the number set.
    logic signed [DATA_W-1:0] set_values [STORE_DEPTH];
    int                       set_count;
    int                       set_capacity;
    logic signed [DATA_W-1:0] set_low;
    logic signed [DATA_W-1:0] set_high;
    logic [DATA_W-1:0]        set_best_gap;

    span_result_t expected_spans [$];
    stim_row_t    directed_rows [$];

    int failures;
    int results_seen;
    int cycle_count;
    int burst_left;
    int random_sent;
    int phase_left;
    int hold_left;
    int holds_done;
    int stall_mode;
    int mode_left;
    logic [DATA_W-1:0] center;
    logic              next_cmd;
    logic [DATA_W-1:0] next_val;

    bounded_set_min_gap_and_range u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rejected      (rejected),
        .span_valid    (span_valid),
        .shortest_span (shortest_span),
        .longest_span  (longest_span),
        .stored_count  (stored_count)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Exact distance between two signed numbers; the 32-bit wrap gives the right answer.
    function automatic logic [DATA_W-1:0] abs_gap(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a >= b) ? DATA_W'(a - b) : DATA_W'(b - a);
    endfunction

    // Applies one transaction to the set model and returns the result it should give.
    task automatic predict_spans(
        input  logic              cmd,
        input  logic [DATA_W-1:0] val,
        output span_result_t      res
    );
        int                room;
        logic [DATA_W-1:0] g;
        room = (set_capacity > STORE_DEPTH) ? STORE_DEPTH : set_capacity;
        res = '0;
        if (cmd == CMD_ADD)
        begin
            if (set_count >= room)
                res.rejected = 1'b1;
            else
            begin
                for (int i = 0; i < set_count; i++)
                begin
                    g = abs_gap(val, set_values[i]);
                    if (g < set_best_gap)
                        set_best_gap = g;
                end
                if (set_count == 0)
                begin
                    set_low  = val;
                    set_high = val;
                end
                else
                begin
                    if ($signed(val) < set_low)
                        set_low = val;
                    if ($signed(val) > set_high)
                        set_high = val;
                end
                set_values[set_count] = val;
                set_count++;
            end
        end
        res.span_valid = (set_count >= MIN_FOR_SPAN);
        if (res.span_valid)
        begin
            res.shortest = set_best_gap;
            res.longest  = abs_gap(set_high, set_low);
        end
        res.count = CAP_W'(set_count);
    endtask

    function automatic string fmt_span(input span_result_t r);
        return $sformatf("rejected=%0d span_valid=%0d shortest=%h longest=%h count=%0d",
                         r.rejected, r.span_valid, r.shortest, r.longest, r.count);
    endfunction

    // Compares the transaction just taken from the output with the oldest expectation.
    task automatic check_span_result();
        span_result_t got;
        span_result_t want;
        got = {rejected, span_valid, shortest_span, longest_span, stored_count};
        if (expected_spans.size() == 0)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("Result %0d arrived with nothing expected: %s",
                         results_seen, fmt_span(got));
        end
        else
        begin
            want = expected_spans.pop_front();
            if (got.rejected !== want.rejected || got.span_valid !== want.span_valid ||
                got.shortest !== want.shortest || got.longest !== want.longest ||
                got.count !== want.count)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("Result %0d mismatch\n  expected %s\n  actual   %s",
                             results_seen, fmt_span(want), fmt_span(got));
            end
        end
    endtask

    // Offers one transaction and, once it is taken, records what it should produce.
    // A known result from the table stands in for the prediction, which still runs.
    task automatic send_transaction(
        input logic              cmd,
        input logic [DATA_W-1:0] val,
        input logic              known,
        input span_result_t      want
    );
        span_result_t res;
        @(negedge clk);
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall);
        predict_spans(cmd, val, res);
        expected_spans.push_back(known ? want : res);
    endtask

    // Sender bursts: a random gap opens each new burst, sometimes none at all.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    // Stops offering and waits until every outstanding result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge clk);
    endtask

    // Capacity is only written with the block idle.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        set_capacity = int'(cap);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic table_row(
        input logic              write_cap,
        input logic [CAP_W-1:0]  cap,
        input logic              cmd,
        input logic [DATA_W-1:0] val,
        input logic              known,
        input logic              rej,
        input logic              valid,
        input logic [DATA_W-1:0] shortest,
        input logic [DATA_W-1:0] longest,
        input int                count
    );
        stim_row_t r;
        r.write_cap       = write_cap;
        r.cap             = cap;
        r.cmd             = cmd;
        r.val             = val;
        r.known           = known;
        r.want.rejected   = rej;
        r.want.span_valid = valid;
        r.want.shortest   = shortest;
        r.want.longest    = longest;
        r.want.count      = CAP_W'(count);
        directed_rows.push_back(r);
    endtask

    // Capacity for a new phase, often placed around the current fill level.
    function automatic logic [CAP_W-1:0] pick_capacity();
        int c;
        case ($urandom_range(0, 7))
            0: c = 0;
            1: c = set_count;
            2: c = set_count + $urandom_range(1, 30);
            3: c = (set_count > 0) ? $urandom_range(0, set_count - 1) : 0;
            4: c = CAP_MAX;
            5: c = STORE_DEPTH;
            6: c = STORE_DEPTH - 1;
            default: c = $urandom_range(0, CAP_MAX);
        endcase
        return CAP_W'(c);
    endfunction

    // Values: wide random, clustered round a centre, repeats of stored ones, extremes.
    function automatic logic [DATA_W-1:0] pick_value(input logic [DATA_W-1:0] mid);
        logic [DATA_W-1:0] v;
        int unsigned       spread;
        spread = 1 << $urandom_range(3, 24);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: v = $urandom;
            7, 8, 9, 10, 11, 12: v = mid + $urandom_range(0, spread) - spread / 2;
            13: v = (set_count > 0) ? set_values[$urandom_range(0, set_count - 1)] : $urandom;
            14, 15:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h8000_0001;
                    default: v = 32'h7FFF_FFFE;
                endcase
            end
            default: v = $urandom_range(0, 2000) - 1000;
        endcase
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] pick_centre();
        logic [DATA_W-1:0] c;
        case ($urandom_range(0, 3))
            0: c = 32'h7FFF_FFF0;
            1: c = 32'h8000_0010;
            2: c = 32'h0000_0000;
            default: c = $urandom;
        endcase
        return c;
    endfunction

    // Receiver: checks each transaction taken and stalls on its own pattern, with two
    // long hold-offs while the sender is busy so that the block backs up to its input.
    initial
    begin
        out_stall  = 1'b0;
        hold_left  = 0;
        holds_done = 0;
        mode_left  = 0;
        stall_mode = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                check_span_result();
                results_seen++;
            end
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (holds_done < 2 && in_valid && results_seen >=
                     ((holds_done == 0) ? FIRST_HOLD_AT : SECOND_HOLD_AT))
            begin
                hold_left = LONG_HOLD - 1;
                holds_done++;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= ($urandom_range(0, 99) < 70);
                    default: out_stall <= ((mode_left % 5) < 2);
                endcase
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus.
    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        command   = CMD_ADD;
        value     = '0;
        failures     = 0;
        results_seen = 0;
        burst_left   = 0;
        set_capacity = int'(CAP_RESET);
        set_count    = 0;
        set_low      = '0;
        set_high     = '0;
        set_best_gap = '1;

        // Directed table: wr, cap, command, value, known, rejected, valid, shortest,
        // longest, count.
        // Empty set after reset, then an add with no room at all.
        table_row(0, 0, CMD_QUERY, 32'h0000_0000, 1, 0, 0, 0, 0, 0);
        table_row(1, 0, CMD_ADD, 32'h0000_0005, 1, 1, 0, 0, 0, 0);
        // The two extremes give the widest possible spans; a single number has none.
        table_row(1, 3, CMD_ADD, 32'h8000_0000, 1, 0, 0, 0, 0, 1);
        table_row(0, 0, CMD_ADD, 32'h7FFF_FFFF, 1, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2);
        table_row(0, 0, CMD_ADD, 32'h0000_0000, 1, 0, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3);
        // Full store drops the add; a query ignores its value.
        table_row(0, 0, CMD_ADD, 32'h0000_0007, 1, 1, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3);
        table_row(0, 0, CMD_QUERY, 32'hDEAD_BEEF, 1, 0, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3);
        // Capacity below the count keeps the set and rejects adds.
        table_row(1, 1, CMD_ADD, 32'h0000_0001, 1, 1, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3);
        // Capacity beyond the store depth; a repeated number closes the gap to zero.
        table_row(1, CAP_MAX, CMD_ADD, 32'h0000_0000, 1, 0, 1, 0, 32'hFFFF_FFFF, 4);
        table_row(0, 0, CMD_ADD, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        table_row(0, 0, CMD_ADD, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
        table_row(0, 0, CMD_ADD, 32'hFFFF_FFFE, 0, 0, 0, 0, 0, 0);
        table_row(0, 0, CMD_QUERY, 32'h5555_AAAA, 0, 0, 0, 0, 0, 0);
        table_row(1, CAP_W'(STORE_DEPTH), CMD_ADD, 32'h1234_5678, 0, 0, 0, 0, 0, 0);
        table_row(0, 0, CMD_ADD, 32'h7FFF_FFFE, 0, 0, 0, 0, 0, 0);
        table_row(0, 0, CMD_ADD, 32'h8000_0001, 0, 0, 0, 0, 0, 0);
        table_row(1, 10, CMD_ADD, 32'h0000_002A, 0, 0, 0, 0, 0, 0);
        table_row(0, 0, CMD_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].write_cap)
                write_capacity(directed_rows[i].cap);
            pace();
            send_transaction(directed_rows[i].cmd, directed_rows[i].val,
                             directed_rows[i].known, directed_rows[i].want);
        end

        // Random phases, each under a fresh capacity.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            write_capacity(pick_capacity());
            center     = pick_centre();
            phase_left = $urandom_range(15, 60);
            while (phase_left > 0 && random_sent < RANDOM_ITEMS)
            begin
                pace();
                if ($urandom_range(0, 99) < 3)
                    drain();
                next_cmd = ($urandom_range(0, 99) < 78) ? CMD_ADD : CMD_QUERY;
                send_transaction(next_cmd, pick_value(center), 1'b0, '0);
                phase_left--;
                random_sent++;
            end
        end

        // A last run of mostly adds under a saturating capacity, then a final query.
        write_capacity(CAP_MAX);
        center = pick_centre();
        repeat (REFILL_ITEMS)
        begin
            pace();
            next_cmd = ($urandom_range(0, 99) < 95) ? CMD_ADD : CMD_QUERY;
            next_val = pick_value(center);
            send_transaction(next_cmd, next_val, 1'b0, '0);
        end
        send_transaction(CMD_QUERY, $urandom, 1'b0, '0);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && expected_spans.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
